@@ hdl/rti_pkg.sv @@
// ----------------------------------------------------------------------------
// rti_pkg
// Shared widths, types and register indexes for the ray/triangle intersector.
// ----------------------------------------------------------------------------
package rti_pkg;

    localparam int COORD_W  = 16;   // Q8.8 coordinate
    localparam int EDGE_W   = 17;   // difference of two coordinates
    localparam int H_W      = 35;   // D x e2
    localparam int Q_W      = 36;   // s x e1
    localparam int ACC_W    = 56;   // dot products, signed
    localparam int WIDE_W   = 55;   // folded magnitudes, unsigned
    localparam int T_W      = 31;   // Q15.16 distance, also divider quotient
    localparam int BARY_W   = 17;   // Q1.16 weight
    localparam int EPS_W    = 16;
    localparam int VTX_W    = 48;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_SHIFT = 15;  // numerator bits that feed the divider steps
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CULL     = 3'd4;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [EDGE_W-1:0]  edge_t;
    typedef logic signed [H_W-1:0]     hv_t;
    typedef logic signed [Q_W-1:0]     qv_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

    typedef struct packed {
        logic [VTX_W-1:0] vertex_a;
        logic [VTX_W-1:0] vertex_b;
        logic [VTX_W-1:0] vertex_c;
        logic [EPS_W-1:0] epsilon;
        logic             cull_back;
    } cfg_t;

    // One classified ray waiting for its divides
    typedef struct packed {
        logic              live;   // passed every test that needs no quotient
        logic [WIDE_W-1:0] det;
        logic [WIDE_W-1:0] un;
        logic [WIDE_W-1:0] vn;
        logic [WIDE_W-1:0] tn;
        logic [T_W-1:0]    t_max;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

@@ hdl/ray_triangle_intersect.sv @@
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Throughput: one ray per cycle while the receiver does not stall the output,
// set by the one-bit-per-stage divider pipes.
// A 4-entry queue parts the geometry stages from the divide stages.
// Reset (synchronous, active low) clears all valid state; vertices to 0,
// epsilon to 7, cull_back to 0.
// ----------------------------------------------------------------------------
module ray_triangle_intersect (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_we,
    input  logic [rti_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [rti_pkg::VTX_W-1:0]       cfg_wdata,
    // ray requests
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_max, pad
    input  logic [127:0]                    s_tdata,
    // results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // t_hit, bary_u, bary_v, pad
    output logic [71:0]                     m_tdata,
    // hit
    output logic [0:0]                      m_tuser
);
    import rti_pkg::*;

    cfg_t            cfg_reg;
    coord_t          origin [0:2];
    coord_t          dir    [0:2];
    logic            push, pop;
    entry_t          push_entry, head;
    queue_status_t   qstat;
    logic            hit;
    logic [T_W-1:0]  t_hit;
    logic [BARY_W-1:0] bary_u, bary_v;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.vertex_a  <= '0;
            cfg_reg.vertex_b  <= '0;
            cfg_reg.vertex_c  <= '0;
            cfg_reg.epsilon   <= EPS_W'(7);
            cfg_reg.cull_back <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_VERTEX_A: cfg_reg.vertex_a  <= cfg_wdata;
                REG_VERTEX_B: cfg_reg.vertex_b  <= cfg_wdata;
                REG_VERTEX_C: cfg_reg.vertex_c  <= cfg_wdata;
                REG_EPSILON:  cfg_reg.epsilon   <= cfg_wdata[EPS_W-1:0];
                REG_CULL:     cfg_reg.cull_back <= cfg_wdata[0];
                default:      cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // Unpack the request
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            origin[k] = coord_t'(s_tdata[k*COORD_W +: COORD_W]);
            dir[k]    = coord_t'(s_tdata[(k+3)*COORD_W +: COORD_W]);
        end
    end

    rti_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .origin   (origin),
        .dir      (dir),
        .t_max    (s_tdata[6*COORD_W +: T_W]),
        .qstat    (qstat),
        .push     (push),
        .entry    (push_entry)
    );

    rti_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    rti_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .epsilon   (cfg_reg.epsilon),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .hit       (hit),
        .t_hit     (t_hit),
        .bary_u    (bary_u),
        .bary_v    (bary_v)
    );

    assign m_tdata = {7'b0, bary_v, bary_u, t_hit};
    assign m_tuser = hit;

endmodule

@@ hdl/rti_div.sv @@
// ----------------------------------------------------------------------------
// rti_div
// Pipelined restoring divider: floor(num * 2^16 / den), one quotient bit per
// stage. Needs num < den * 2^15 so that the quotient fits in 31 bits.
// ----------------------------------------------------------------------------
module rti_div (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [rti_pkg::WIDE_W-1:0] num,
    input  logic [rti_pkg::WIDE_W-1:0] den,
    output logic [rti_pkg::T_W-1:0]   quot
);
    import rti_pkg::*;

    logic [WIDE_W-1:0]    rem_reg  [0:T_W-1];
    logic [WIDE_W-1:0]    den_reg  [0:T_W-1];
    logic [DIV_SHIFT-1:0] low_reg  [0:T_W-1];
    logic [T_W-1:0]       quot_reg [0:T_W];

    logic [WIDE_W-1:0]    rem_next [0:T_W-1];
    logic                 qbit     [0:T_W-1];

    // Trial subtract for every step; the low numerator bits shift out MSB first
    always_comb begin
        logic [WIDE_W:0]   shifted;
        logic [WIDE_W+1:0] diff;
        for (int j = 0; j < T_W; j++) begin
            shifted = {rem_reg[j], low_reg[j][DIV_SHIFT-1]};
            diff = {1'b0, shifted} - {2'b00, den_reg[j]};
            qbit[j] = ~diff[WIDE_W+1];
            rem_next[j] = qbit[j] ? diff[WIDE_W-1:0] : shifted[WIDE_W-1:0];
        end
    end

    // Load stage and step stages
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= {{DIV_SHIFT{1'b0}}, num[WIDE_W-1:DIV_SHIFT]};
            den_reg[0]  <= den;
            low_reg[0]  <= num[DIV_SHIFT-1:0];
            quot_reg[0] <= '0;
            for (int j = 0; j < T_W-1; j++) begin
                rem_reg[j+1] <= rem_next[j];
                den_reg[j+1] <= den_reg[j];
                low_reg[j+1] <= {low_reg[j][DIV_SHIFT-2:0], 1'b0};
            end
            for (int j = 0; j < T_W; j++) begin
                quot_reg[j+1] <= {quot_reg[j][T_W-2:0], qbit[j]};
            end
        end
    end

    assign quot = quot_reg[T_W];

endmodule

@@ hdl/rti_front.sv @@
// ----------------------------------------------------------------------------
// rti_front
// Geometry pipeline: edges, cross products, dot products, then the early
// tests on determinant, u, v and t. Emits one classified entry per ray.
// ----------------------------------------------------------------------------
module rti_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rti_pkg::cfg_t          cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  rti_pkg::coord_t        origin [0:2],
    input  rti_pkg::coord_t        dir    [0:2],
    input  logic [rti_pkg::T_W-1:0] t_max,
    input  rti_pkg::queue_status_t qstat,
    output logic                   push,
    output rti_pkg::entry_t        entry
);
    import rti_pkg::*;

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    coord_t va [0:2];
    coord_t vb [0:2];
    coord_t vc [0:2];

    edge_t d1_reg [0:2], s1_reg [0:2], e1_1_reg [0:2], e2_1_reg [0:2];
    edge_t d2_reg [0:2], s2_reg [0:2], e1_2_reg [0:2], e2_2_reg [0:2];
    hv_t   h2_reg [0:2];
    qv_t   q2_reg [0:2];
    acc_t  pd_reg [0:2], pu_reg [0:2], pv_reg [0:2], pt_reg [0:2];
    acc_t  det_reg, un_reg, vn_reg, tn_reg;
    logic [T_W-1:0] tm1_reg, tm2_reg, tm3_reg, tm4_reg;
    entry_t entry_reg;

    logic              entry_next_live;
    logic [WIDE_W-1:0] entry_next_det, entry_next_un, entry_next_vn, entry_next_tn;

    // Whole front moves unless its last entry is blocked by a full queue
    assign adv      = ~(v5_reg & qstat.full);
    assign in_ready = adv;
    assign push     = v5_reg & ~qstat.full;
    assign entry    = entry_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            va[k] = coord_t'(cfg.vertex_a[k*COORD_W +: COORD_W]);
            vb[k] = coord_t'(cfg.vertex_b[k*COORD_W +: COORD_W]);
            vc[k] = coord_t'(cfg.vertex_c[k*COORD_W +: COORD_W]);
        end
    end

    // Valid pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Stage 1: edges and origin offset
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                d1_reg[k]   <= EDGE_W'(dir[k]);
                s1_reg[k]   <= EDGE_W'(origin[k]) - EDGE_W'(va[k]);
                e1_1_reg[k] <= EDGE_W'(vb[k]) - EDGE_W'(va[k]);
                e2_1_reg[k] <= EDGE_W'(vc[k]) - EDGE_W'(va[k]);
            end
            tm1_reg <= t_max;
        end
    end

    // Stage 2: h = D x e2, q = s x e1
    always_ff @(posedge aclk) begin
        if (adv) begin
            h2_reg[0] <= H_W'(d1_reg[1]) * H_W'(e2_1_reg[2]) - H_W'(d1_reg[2]) * H_W'(e2_1_reg[1]);
            h2_reg[1] <= H_W'(d1_reg[2]) * H_W'(e2_1_reg[0]) - H_W'(d1_reg[0]) * H_W'(e2_1_reg[2]);
            h2_reg[2] <= H_W'(d1_reg[0]) * H_W'(e2_1_reg[1]) - H_W'(d1_reg[1]) * H_W'(e2_1_reg[0]);
            q2_reg[0] <= Q_W'(s1_reg[1]) * Q_W'(e1_1_reg[2]) - Q_W'(s1_reg[2]) * Q_W'(e1_1_reg[1]);
            q2_reg[1] <= Q_W'(s1_reg[2]) * Q_W'(e1_1_reg[0]) - Q_W'(s1_reg[0]) * Q_W'(e1_1_reg[2]);
            q2_reg[2] <= Q_W'(s1_reg[0]) * Q_W'(e1_1_reg[1]) - Q_W'(s1_reg[1]) * Q_W'(e1_1_reg[0]);
            d2_reg  <= d1_reg;
            s2_reg  <= s1_reg;
            e1_2_reg <= e1_1_reg;
            e2_2_reg <= e2_1_reg;
            tm2_reg <= tm1_reg;
        end
    end

    // Stage 3: dot product terms
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                pd_reg[k] <= ACC_W'(e1_2_reg[k]) * ACC_W'(h2_reg[k]);
                pu_reg[k] <= ACC_W'(s2_reg[k])   * ACC_W'(h2_reg[k]);
                pv_reg[k] <= ACC_W'(d2_reg[k])   * ACC_W'(q2_reg[k]);
                pt_reg[k] <= ACC_W'(e2_2_reg[k]) * ACC_W'(q2_reg[k]);
            end
            tm3_reg <= tm2_reg;
        end
    end

    // Stage 4: det and the three numerators
    always_ff @(posedge aclk) begin
        if (adv) begin
            det_reg <= pd_reg[0] + pd_reg[1] + pd_reg[2];
            un_reg  <= pu_reg[0] + pu_reg[1] + pu_reg[2];
            vn_reg  <= pv_reg[0] + pv_reg[1] + pv_reg[2];
            tn_reg  <= pt_reg[0] + pt_reg[1] + pt_reg[2];
            tm4_reg <= tm3_reg;
        end
    end

    // Stage 5: sign fold and early tests
    always_comb begin
        acc_t eps_sc, det_p, un_p, vn_p, tn_p;
        logic neg, below, above_neg, kill;
        eps_sc    = acc_t'({cfg.epsilon, 8'h00});
        below     = det_reg < eps_sc;
        above_neg = det_reg > -eps_sc;
        neg       = det_reg[ACC_W-1];
        det_p     = neg ? -det_reg : det_reg;
        un_p      = neg ? -un_reg  : un_reg;
        vn_p      = neg ? -vn_reg  : vn_reg;
        tn_p      = neg ? -tn_reg  : tn_reg;
        kill      = cfg.cull_back ? below : (below & above_neg);
        kill      = kill | (det_reg == '0);
        kill      = kill | un_p[ACC_W-1] | (un_p > det_p);
        kill      = kill | vn_p[ACC_W-1] | ((un_p + vn_p) > det_p);
        kill      = kill | tn_p[ACC_W-1] | (tn_p == '0);
        // quotient of t would not fit in 31 bits, so it lies beyond any t_max
        kill      = kill | ((tn_p >>> DIV_SHIFT) >= det_p);
        entry_next_live = ~kill;
        entry_next_det  = det_p[WIDE_W-1:0];
        entry_next_un   = un_p[WIDE_W-1:0];
        entry_next_vn   = vn_p[WIDE_W-1:0];
        entry_next_tn   = tn_p[WIDE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            entry_reg.live  <= entry_next_live;
            entry_reg.det   <= entry_next_det;
            entry_reg.un    <= entry_next_un;
            entry_reg.vn    <= entry_next_vn;
            entry_reg.tn    <= entry_next_tn;
            entry_reg.t_max <= tm4_reg;
        end
    end

endmodule

@@ hdl/rti_queue.sv @@
// ----------------------------------------------------------------------------
// rti_queue
// Short FIFO of classified requests between the front and the divide stages.
// ----------------------------------------------------------------------------
module rti_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  rti_pkg::entry_t        push_entry,
    input  logic                   pop,
    output rti_pkg::entry_t        head,
    output rti_pkg::queue_status_t qstat
);
    import rti_pkg::*;

    entry_t                 mem [0:QUEUE_DEPTH-1];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_push, do_pop;

    assign qstat.full  = count_reg == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign qstat.empty = count_reg == '0;
    assign do_push     = push & ~qstat.full;
    assign do_pop      = pop & ~qstat.empty;
    assign head        = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ hdl/rti_back.sv @@
// ----------------------------------------------------------------------------
// rti_back
// Divide stages for t, u and v, final distance tests and the output register.
// ----------------------------------------------------------------------------
module rti_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [rti_pkg::EPS_W-1:0]   epsilon,
    input  rti_pkg::entry_t             head,
    input  rti_pkg::queue_status_t      qstat,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        hit,
    output logic [rti_pkg::T_W-1:0]     t_hit,
    output logic [rti_pkg::BARY_W-1:0]  bary_u,
    output logic [rti_pkg::BARY_W-1:0]  bary_v
);
    import rti_pkg::*;

    logic adv;
    logic           vld_reg  [0:T_W];
    logic           live_reg [0:T_W];
    logic [T_W-1:0] tmax_reg [0:T_W];
    logic [T_W-1:0] tq, uq, vq;
    logic           hit_now;

    logic                  out_valid_reg, hit_reg;
    logic [T_W-1:0]        t_hit_reg;
    logic [BARY_W-1:0]     bary_u_reg, bary_v_reg;

    assign adv = ~out_valid_reg | out_ready;
    assign pop = adv & ~qstat.empty;

    rti_div u_div_t (.aclk(aclk), .en(adv), .num(head.tn), .den(head.det), .quot(tq));
    rti_div u_div_u (.aclk(aclk), .en(adv), .num(head.un), .den(head.det), .quot(uq));
    rti_div u_div_v (.aclk(aclk), .en(adv), .num(head.vn), .den(head.det), .quot(vq));

    // Request tags that travel beside the dividers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= T_W; j++) vld_reg[j] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= ~qstat.empty;
            for (int j = 0; j < T_W; j++) vld_reg[j+1] <= vld_reg[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            live_reg[0] <= head.live;
            tmax_reg[0] <= head.t_max;
            for (int j = 0; j < T_W; j++) begin
                live_reg[j+1] <= live_reg[j];
                tmax_reg[j+1] <= tmax_reg[j];
            end
        end
    end

    // epsilon < t <= t_max
    assign hit_now = live_reg[T_W] & (tq > T_W'(epsilon)) & (tq <= tmax_reg[T_W]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= vld_reg[T_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hit_reg    <= hit_now;
            t_hit_reg  <= hit_now ? tq : '0;
            bary_u_reg <= hit_now ? uq[BARY_W-1:0] : '0;
            bary_v_reg <= hit_now ? vq[BARY_W-1:0] : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign t_hit     = t_hit_reg;
    assign bary_u    = bary_u_reg;
    assign bary_v    = bary_v_reg;

endmodule

@@ test/ray_triangle_intersect_test.sv @@
// ----------------------------------------------------------------------------
// ray_triangle_intersect_test
// Streams rays at the intersector under several triangles, epsilons and face
// modes, predicts every result with an exact wide-integer model and checks
// each result field by field, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rti_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic [T_W-1:0] t_max;
        coord_t dz, dy, dx, oz, oy, ox;
    } ray_t;

    typedef struct packed {
        logic           hit;
        logic [T_W-1:0] t_hit;
        logic [BARY_W-1:0] u;
        logic [BARY_W-1:0] v;
    } isect_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [VTX_W-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [127:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [0:0] m_tuser;

    // triangle and mode as the predictor sees them
    logic [VTX_W-1:0] tri_vtx [3];
    logic [EPS_W-1:0] eps_q;
    logic cull_q;

    isect_t expected_hits [$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    int errors = 0;
    int checked = 0;
    int hits_seen = 0;
    longint cycles = 0;

    ray_triangle_intersect dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver readiness
    always @(posedge aclk) begin
        if (hold_off) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // result checker
    always @(posedge aclk) begin
        isect_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit = m_tuser[0];
            got.t_hit = m_tdata[30:0];
            got.u = m_tdata[47:31];
            got.v = m_tdata[64:48];
            if (expected_hits.size() == 0) begin
                $display("result with no request outstanding");
                errors++;
            end else begin
                want = expected_hits.pop_front();
                if (got.hit !== want.hit)
                    report_mismatch("hit", longint'(got.hit), longint'(want.hit));
                if (got.t_hit !== want.t_hit)
                    report_mismatch("t_hit", longint'(got.t_hit), longint'(want.t_hit));
                if (got.u !== want.u)
                    report_mismatch("bary_u", longint'(got.u), longint'(want.u));
                if (got.v !== want.v)
                    report_mismatch("bary_v", longint'(got.v), longint'(want.v));
                checked++;
                if (got.hit) hits_seen++;
            end
        end
    end

    function automatic wide_t vtx_comp(int n, int k);
        coord_t c;
        c = tri_vtx[n][k*COORD_W +: COORD_W];
        return wide_t'(c);
    endfunction

    // exact Moller-Trumbore, all sums at full width
    function automatic isect_t predict_hit(ray_t r);
        isect_t res;
        wide_t a[3], e1[3], e2[3], s[3], d[3], h[3], q[3];
        wide_t det, un, vn, tn, epsw, tq;
        res = '0;
        for (int k = 0; k < 3; k++) begin
            a[k] = vtx_comp(0, k);
            e1[k] = vtx_comp(1, k) - a[k];
            e2[k] = vtx_comp(2, k) - a[k];
        end
        s[0] = wide_t'(r.ox) - a[0]; s[1] = wide_t'(r.oy) - a[1]; s[2] = wide_t'(r.oz) - a[2];
        d[0] = wide_t'(r.dx); d[1] = wide_t'(r.dy); d[2] = wide_t'(r.dz);
        h[0] = d[1]*e2[2] - d[2]*e2[1];
        h[1] = d[2]*e2[0] - d[0]*e2[2];
        h[2] = d[0]*e2[1] - d[1]*e2[0];
        det = e1[0]*h[0] + e1[1]*h[1] + e1[2]*h[2];
        // det scaled by 2^24 against eps scaled by 2^16: det against eps << 8
        epsw = wide_t'({1'b0, eps_q}) <<< 8;
        if (cull_q) begin
            if ((det <<< 16) < (epsw <<< 16)) return res;
        end else if ((det <<< 16) < (epsw <<< 16) && -(epsw <<< 16) < (det <<< 16)) begin
            return res;
        end
        if (det == 0) return res;
        un = s[0]*h[0] + s[1]*h[1] + s[2]*h[2];
        q[0] = s[1]*e1[2] - s[2]*e1[1];
        q[1] = s[2]*e1[0] - s[0]*e1[2];
        q[2] = s[0]*e1[1] - s[1]*e1[0];
        vn = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
        tn = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
        if (det < 0) begin
            det = -det; un = -un; vn = -vn; tn = -tn;
        end
        if (un < 0 || un > det) return res;
        if (vn < 0 || un + vn > det) return res;
        if (tn <= 0) return res;
        tq = (tn <<< 16) / det;
        if (tq <= wide_t'({1'b0, eps_q})) return res;
        if (tq > wide_t'({1'b0, r.t_max})) return res;
        res.hit = 1'b1;
        res.t_hit = tq[T_W-1:0];
        res.u = BARY_W'((un <<< 16) / det);
        res.v = BARY_W'((vn <<< 16) / det);
        return res;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VTX_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_VERTEX_A: tri_vtx[0] = val;
            REG_VERTEX_B: tri_vtx[1] = val;
            REG_VERTEX_C: tri_vtx[2] = val;
            REG_EPSILON:  eps_q = val[EPS_W-1:0];
            REG_CULL:     cull_q = val[0];
            default: ;
        endcase
    endtask

    task automatic set_triangle(input logic [VTX_W-1:0] va, vb, vc,
                                input logic [EPS_W-1:0] eps, input logic cull);
        write_reg(REG_VERTEX_A, va);
        write_reg(REG_VERTEX_B, vb);
        write_reg(REG_VERTEX_C, vc);
        write_reg(REG_EPSILON, VTX_W'(eps));
        write_reg(REG_CULL, VTX_W'(cull));
    endtask

    // sends one request; valid stays up across back-to-back requests
    task automatic send_ray(input ray_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, r};
        expected_hits = {expected_hits, predict_hit(r)};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function automatic logic [VTX_W-1:0] pack_vtx(int x, int y, int z);
        return {coord_t'(z), coord_t'(y), coord_t'(x)};
    endfunction

    function automatic int near(int centre, int spread);
        return centre + int'($urandom_range(2*spread)) - spread;
    endfunction

    // a ray aimed roughly at the current triangle, or pure noise
    function automatic ray_t random_ray();
        ray_t r;
        logic [127:0] noise;
        int tx, ty, tz, ox, oy, oz;
        if ($urandom_range(9) < 2) begin
            noise = {$urandom(), $urandom(), $urandom(), $urandom()};
            r = noise[126:0];
            return r;
        end
        tx = int'((vtx_comp(0,0) + vtx_comp(1,0) + vtx_comp(2,0)) / 3);
        ty = int'((vtx_comp(0,1) + vtx_comp(1,1) + vtx_comp(2,1)) / 3);
        tz = int'((vtx_comp(0,2) + vtx_comp(1,2) + vtx_comp(2,2)) / 3);
        ox = near(tx, 3000); oy = near(ty, 3000); oz = near(tz + 4000, 3000);
        r.ox = coord_t'(ox); r.oy = coord_t'(oy); r.oz = coord_t'(oz);
        r.dx = coord_t'(tx - ox + int'($urandom_range(800)) - 400);
        r.dy = coord_t'(ty - oy + int'($urandom_range(800)) - 400);
        r.dz = coord_t'(tz - oz + int'($urandom_range(800)) - 400);
        if ($urandom_range(3) == 0) begin
            r.dx = -r.dx; r.dy = -r.dy; r.dz = -r.dz;
        end
        r.t_max = ($urandom_range(3) == 0) ? T_W'($urandom_range(200000))
                                          : {T_W{1'b1}};
        return r;
    endfunction

    function automatic ray_t make_ray(int ox, oy, oz, dx, dy, dz, tm);
        ray_t r;
        r.ox = coord_t'(ox); r.oy = coord_t'(oy); r.oz = coord_t'(oz);
        r.dx = coord_t'(dx); r.dy = coord_t'(dy); r.dz = coord_t'(dz);
        r.t_max = T_W'(tm);
        return r;
    endfunction

    // directed: hits, edges, back faces, parallel rays, extremes
    task automatic test_directed();
        set_triangle(pack_vtx(0, 0, 0), pack_vtx(256, 0, 0), pack_vtx(0, 256, 0),
                     16'd7, 1'b0);
        send_ray(make_ray(64, 64, 256, 0, 0, -256, '1));       // straight hit
        send_ray(make_ray(64, 64, -256, 0, 0, 256, '1));       // from behind
        send_ray(make_ray(0, 0, 256, 0, 0, -256, '1));         // on vertex a
        send_ray(make_ray(128, 128, 256, 0, 0, -256, '1));     // on far edge
        send_ray(make_ray(200, 200, 256, 0, 0, -256, '1));     // outside
        send_ray(make_ray(64, 64, 256, 256, 0, 0, '1));        // parallel
        send_ray(make_ray(64, 64, 256, 0, 0, 256, '1));        // pointing away
        send_ray(make_ray(64, 64, 256, 0, 0, -256, 65536));    // t_max exactly
        send_ray(make_ray(64, 64, 256, 0, 0, -256, 65535));    // just beyond t_max
        send_ray(make_ray(64, 64, 0, 0, 0, -256, '1));         // origin on plane
        send_ray(make_ray(-32768, -32768, -32768, -32768, -32768, -32768, 0));
        send_ray(make_ray(32767, 32767, 32767, 32767, 32767, 32767, '1));
        send_ray(make_ray(-32768, 32767, -32768, 32767, -32768, 32767, '1));
        drain();
        // back-face cull: from behind must now miss
        write_reg(REG_CULL, VTX_W'(1));
        send_ray(make_ray(64, 64, 256, 0, 0, -256, '1));
        send_ray(make_ray(64, 64, -256, 0, 0, 256, '1));
        drain();
        // zero epsilon: degenerate triangle has det exactly 0
        set_triangle(pack_vtx(0, 0, 0), pack_vtx(256, 0, 0), pack_vtx(512, 0, 0),
                     16'd0, 1'b0);
        send_ray(make_ray(64, 0, 256, 0, 0, -256, '1));
        send_ray(make_ray(64, 64, 256, 0, 0, -256, '1));
        drain();
        // extreme vertices and the largest epsilon
        set_triangle({VTX_W{1'b1}}, pack_vtx(32767, 32767, 32767),
                     pack_vtx(-32768, 32767, -32768), 16'hFFFF, 1'b0);
        send_ray(make_ray(0, 0, 0, 100, -200, 300, '1));
        send_ray(make_ray(-32768, 32767, 0, 32767, -32768, 1, '1));
        drain();
    endtask

    task automatic random_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) send_ray(random_ray());
        drain();
    endtask

    task automatic random_triangle(logic cull);
        logic [EPS_W-1:0] eps;
        eps = ($urandom_range(3) == 0) ? EPS_W'($urandom()) : EPS_W'($urandom_range(8));
        set_triangle(pack_vtx(near(0, 6000), near(0, 6000), near(0, 2000)),
                     pack_vtx(near(6000, 4000), near(0, 4000), near(0, 2000)),
                     pack_vtx(near(0, 4000), near(6000, 4000), near(0, 2000)),
                     eps, cull);
    endtask

    // random rays over several triangles and every idling phase
    task automatic test_random();
        for (int p = 0; p < 8; p++) begin
            random_triangle(p[0]);
            case (p % 4)
                0: random_phase(50, 0, 0);
                1: random_phase(50, 76, 0);
                2: random_phase(50, 0, 76);
                default: random_phase(50, 24, 24);
            endcase
        end
    endtask

    // receiver holds off while requests keep coming, filling the pipe
    task automatic test_backpressure();
        random_triangle(1'b0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            repeat (80) send_ray(random_ray());
        join
        drain();
    endtask

    initial begin
        tri_vtx[0] = '0; tri_vtx[1] = '0; tri_vtx[2] = '0;
        eps_q = 16'd7;
        cull_q = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        test_backpressure();
        $display("checked %0d results (%0d hits) over directed, random and backpressure runs",
                 checked, hits_seen);
        if (errors == 0 && expected_hits.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/rti_pkg.sv
hdl/rti_div.sv
hdl/rti_front.sv
hdl/rti_queue.sv
hdl/rti_back.sv
hdl/ray_triangle_intersect.sv
test/ray_triangle_intersect_test.sv
